FILE: rtl/thq_pkg.sv
package thq_pkg;

   localparam int DEF_CAPACITY     = 64;
   localparam int DEF_TIME_BITS    = 48;
   localparam int DEF_HANDLER_BITS = 16;
   localparam int DEF_CONTEXT_BITS = 32;

   localparam logic [1:0] ACT_SCHEDULE   = 2'd0;
   localparam logic [1:0] ACT_CANCEL_ID  = 2'd1;
   localparam logic [1:0] ACT_CANCEL_HDL = 2'd2;
   localparam logic [1:0] ACT_REMOVE     = 2'd3;

   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_FULL      = 2'd1;
   localparam logic [1:0] STS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STS_EMPTY     = 2'd3;

endpackage

FILE: rtl/timer_heap_queue.sv
// Flow per action: schedule takes the head of the free list, then climbs a level per compare;
// remove earliest takes the root and moves any refill entry down; cancel by id checks the
// in-use flag, then removes that slot, and its refill entry climbs or goes down; cancel by
// handler scans slots in order, removing each match. Full, empty, unknown id skip heap work.
// Throughput: one item at a time, busy until the result. Reset clears control, occupancy,
// free list head and id flags; heap memories undefined until written. No backpressure.
module timer_heap_queue #(
   parameter int CAPACITY     = thq_pkg::DEF_CAPACITY,
   parameter int TIME_BITS    = thq_pkg::DEF_TIME_BITS,
   parameter int HANDLER_BITS = thq_pkg::DEF_HANDLER_BITS,
   parameter int CONTEXT_BITS = thq_pkg::DEF_CONTEXT_BITS,
   localparam int IW          = $clog2(CAPACITY),
   localparam int CW          = $clog2(CAPACITY + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_action,
   input  logic [TIME_BITS-1:0]    req_expiry_time,
   input  logic [HANDLER_BITS-1:0] req_handler_tag,
   input  logic [CONTEXT_BITS-1:0] req_context_tag,
   input  logic [IW-1:0]           req_target_id,
   input  logic                    req_suppress_notify,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic [IW-1:0]           rsp_tmr_id,
   output logic [TIME_BITS-1:0]    rsp_out_time,
   output logic [HANDLER_BITS-1:0] rsp_out_handler,
   output logic [CONTEXT_BITS-1:0] rsp_out_context,
   output logic [CW-1:0]           rsp_cancel_count,
   output logic                    rsp_notify_cancel,
   output logic [CW-1:0]           rsp_occupancy,
   output logic [TIME_BITS-1:0]    rsp_head_time
);
   import thq_pkg::*;

   // heap entry: {time, handler, id}
   localparam int EW = TIME_BITS + HANDLER_BITS + IW;
   localparam int DW = IW + 2;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_SCH      = 4'd1;
   localparam logic [3:0] ST_CID      = 4'd2;
   localparam logic [3:0] ST_TAKE     = 4'd3;
   localparam logic [3:0] ST_UP_RD    = 4'd4;
   localparam logic [3:0] ST_UP_CMP   = 4'd5;
   localparam logic [3:0] ST_DN_RD    = 4'd6;
   localparam logic [3:0] ST_DN_CMP   = 4'd7;
   localparam logic [3:0] ST_SCAN_RD  = 4'd8;
   localparam logic [3:0] ST_SCAN_CMP = 4'd9;
   localparam logic [3:0] ST_FIN      = 4'd10;
   localparam logic [3:0] ST_RSP      = 4'd11;

   logic [3:0]              state_ff, state_in;
   logic [1:0]              act_ff, act_in;
   logic [TIME_BITS-1:0]    time_ff, time_in;
   logic [HANDLER_BITS-1:0] hdl_ff, hdl_in;
   logic [CONTEXT_BITS-1:0] ctx_ff, ctx_in;
   logic                    sup_ff, sup_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           free_ff, free_in;
   logic [IW-1:0]           pos_ff, pos_in;
   logic [IW-1:0]           slot_ff, slot_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic [EW-1:0]           mv_ff, mv_in;
   logic                    first_ff, first_in;
   logic [1:0]              status_ff, status_in;
   logic [IW-1:0]           tid_ff, tid_in;
   logic [TIME_BITS-1:0]    otime_ff, otime_in;
   logic [HANDLER_BITS-1:0] ohdl_ff, ohdl_in;
   logic [CW-1:0]           ccnt_ff, ccnt_in;
   logic                    notify_ff, notify_in;

   // memory ports
   logic [IW-1:0]           h_ra, h_rb, h_wa;
   logic [EW-1:0]           h_qa, h_qb, h_wd;
   logic                    h_we;
   logic [IW-1:0]           l_ra, l_wa;
   logic [CW-1:0]           l_q, l_wd;
   logic                    l_we;
   logic                    c_re, c_we;
   logic [IW-1:0]           c_ra;
   logic [CONTEXT_BITS-1:0] c_q;
   logic                    u_we, u_wd, u_rd;
   logic [IW-1:0]           u_wa;

   thq_heap_mem #(.CAPACITY(CAPACITY), .ENTRY_BITS(EW)) u_heap (
      .clock     (clock),
      .rd_addr_a (h_ra),
      .rd_addr_b (h_rb),
      .rd_data_a (h_qa),
      .rd_data_b (h_qb),
      .wr_en     (h_we),
      .wr_addr   (h_wa),
      .wr_data   (h_wd)
   );

   thq_id_table #(.CAPACITY(CAPACITY), .CONTEXT_BITS(CONTEXT_BITS)) u_ids (
      .clock        (clock),
      .reset        (reset),
      .link_rd_addr (l_ra),
      .link_rd_data (l_q),
      .link_wr_en   (l_we),
      .link_wr_addr (l_wa),
      .link_wr_data (l_wd),
      .ctx_rd_en    (c_re),
      .ctx_rd_addr  (c_ra),
      .ctx_rd_data  (c_q),
      .ctx_wr_en    (c_we),
      .ctx_wr_addr  (slot_in),
      .ctx_wr_data  (ctx_ff),
      .use_wr_en    (u_we),
      .use_wr_addr  (u_wa),
      .use_wr_data  (u_wd),
      .use_rd_addr  (req_target_id),
      .use_rd_data  (u_rd)
   );

   // entry fields
   logic [TIME_BITS-1:0]    qa_time, qb_time, mv_time;
   logic [HANDLER_BITS-1:0] qa_hdl;
   logic [IW-1:0]           qa_id, mv_id;
   assign qa_time = h_qa[EW-1 -: TIME_BITS];
   assign qb_time = h_qb[EW-1 -: TIME_BITS];
   assign mv_time = mv_ff[EW-1 -: TIME_BITS];
   assign qa_hdl  = h_qa[IW +: HANDLER_BITS];
   assign qa_id   = h_qa[IW-1:0];
   assign mv_id   = mv_ff[IW-1:0];

   logic [IW-1:0] last_slot, parent;
   logic [DW-1:0] child_a, child_b;
   logic [CW-1:0] count_dec;
   logic          pick_b;
   logic [EW-1:0] pick;
   logic [DW-1:0] pick_pos;
   logic [IW-1:0] next_done_dummy;

   assign last_slot = IW'(count_ff - CW'(1));
   assign parent    = IW'((pos_ff - IW'(1)) >> 1);
   assign child_a   = {1'b0, pos_ff, 1'b1};
   assign child_b   = child_a + DW'(1);
   assign count_dec = count_ff - CW'(1);
   assign pick_b    = (child_b < DW'(count_ff)) && (qb_time < qa_time);
   assign pick      = pick_b ? h_qb : h_qa;
   assign pick_pos  = pick_b ? child_b : child_a;
   assign next_done_dummy = '0;

   logic [3:0] st_done;
   assign st_done = (act_ff == ACT_CANCEL_HDL) ? ST_SCAN_RD : ST_FIN;

   always_comb begin
      state_in  = state_ff;
      act_in    = act_ff;
      time_in   = time_ff;
      hdl_in    = hdl_ff;
      ctx_in    = ctx_ff;
      sup_in    = sup_ff;
      count_in  = count_ff;
      free_in   = free_ff;
      pos_in    = pos_ff;
      slot_in   = slot_ff;
      idx_in    = idx_ff;
      mv_in     = mv_ff;
      first_in  = first_ff;
      status_in = status_ff;
      tid_in    = tid_ff;
      otime_in  = otime_ff;
      ohdl_in   = ohdl_ff;
      ccnt_in   = ccnt_ff;
      notify_in = notify_ff;
      h_ra = slot_ff;
      h_rb = last_slot;
      h_we = 1'b0;
      h_wa = pos_ff;
      h_wd = mv_ff;
      l_ra = free_ff[IW-1:0];
      l_we = 1'b0;
      l_wa = mv_id;
      l_wd = CW'(pos_ff);
      c_re = 1'b0;
      c_ra = qa_id;
      c_we = 1'b0;
      u_we = 1'b0;
      u_wa = qa_id;
      u_wd = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_action == ACT_CANCEL_ID) begin
               l_ra = req_target_id;
            end
            h_ra = '0;
            if (start) begin
               act_in    = req_action;
               time_in   = req_expiry_time;
               hdl_in    = req_handler_tag;
               ctx_in    = req_context_tag;
               sup_in    = req_suppress_notify;
               status_in = STS_OK;
               tid_in    = '0;
               otime_in  = '0;
               ohdl_in   = '0;
               ccnt_in   = '0;
               notify_in = 1'b0;
               case (req_action)
                  ACT_SCHEDULE: begin
                     if (count_ff >= CW'(CAPACITY) || free_ff >= CW'(CAPACITY)) begin
                        status_in = STS_FULL;
                        state_in  = ST_FIN;
                     end else begin
                        state_in = ST_SCH;
                     end
                  end
                  ACT_CANCEL_ID: begin
                     // in-use flag and link are read here, checked next cycle
                     if (CW'(req_target_id) >= CW'(CAPACITY)) begin
                        status_in = STS_NOT_FOUND;
                        state_in  = ST_FIN;
                     end else begin
                        state_in  = ST_CID;
                     end
                  end
                  ACT_CANCEL_HDL: begin
                     idx_in    = '0;
                     ohdl_in   = req_handler_tag;
                     notify_in = !req_suppress_notify;
                     state_in  = ST_SCAN_RD;
                  end
                  default: begin
                     if (count_ff == '0) begin
                        status_in = STS_EMPTY;
                        state_in  = ST_FIN;
                     end else begin
                        slot_in  = '0;
                        state_in = ST_TAKE;
                     end
                  end
               endcase
            end
         end

         ST_SCH: begin
            // new id from the free list head; context write uses slot_in as id
            slot_in  = free_ff[IW-1:0];
            free_in  = l_q;
            c_we     = 1'b1;
            u_we     = 1'b1;
            u_wa     = free_ff[IW-1:0];
            u_wd     = 1'b1;
            mv_in    = {time_ff, hdl_ff, free_ff[IW-1:0]};
            pos_in   = count_ff[IW-1:0];
            count_in = count_ff + CW'(1);
            tid_in   = free_ff[IW-1:0];
            first_in = 1'b0;
            state_in = ST_UP_RD;
         end

         ST_CID: begin
            if (!u_rd) begin
               status_in = STS_NOT_FOUND;
               state_in  = ST_FIN;
            end else begin
               ccnt_in   = CW'(1);
               notify_in = !sup_ff;
               slot_in   = l_q[IW-1:0];
               h_ra      = l_q[IW-1:0];
               state_in  = ST_TAKE;
            end
         end

         ST_TAKE: begin
            // qa: removed entry, qb: last entry
            l_we     = 1'b1;
            l_wa     = qa_id;
            l_wd     = free_ff;
            u_we     = 1'b1;
            u_wa     = qa_id;
            u_wd     = 1'b0;
            c_re     = 1'b1;
            free_in  = CW'(qa_id);
            count_in = count_dec;
            if (act_ff == ACT_CANCEL_HDL) begin
               ccnt_in = ccnt_ff + CW'(1);
            end else begin
               tid_in   = qa_id;
               otime_in = qa_time;
               ohdl_in  = qa_hdl;
            end
            if (CW'(slot_ff) < count_dec) begin
               mv_in    = h_qb;
               pos_in   = slot_ff;
               first_in = 1'b1;
               state_in = (slot_ff == '0) ? ST_DN_RD : ST_UP_RD;
            end else begin
               state_in = st_done;
            end
         end

         ST_UP_RD: begin
            h_ra = parent;
            if (pos_ff == '0) begin
               h_we     = 1'b1;
               l_we     = 1'b1;
               state_in = st_done;
            end else begin
               state_in = ST_UP_CMP;
            end
         end

         ST_UP_CMP: begin
            if (mv_time < qa_time) begin
               h_we     = 1'b1;
               h_wd     = h_qa;
               l_we     = 1'b1;
               l_wa     = qa_id;
               pos_in   = parent;
               first_in = 1'b0;
               state_in = ST_UP_RD;
            end else if (first_ff) begin
               // moved entry not below its parent: go down instead
               first_in = 1'b0;
               state_in = ST_DN_RD;
            end else begin
               h_we     = 1'b1;
               l_we     = 1'b1;
               state_in = st_done;
            end
         end

         ST_DN_RD: begin
            h_ra = child_a[IW-1:0];
            h_rb = child_b[IW-1:0];
            if (child_a >= DW'(count_ff)) begin
               h_we     = 1'b1;
               l_we     = 1'b1;
               state_in = st_done;
            end else begin
               state_in = ST_DN_CMP;
            end
         end

         ST_DN_CMP: begin
            if (pick[EW-1 -: TIME_BITS] < mv_time) begin
               h_we     = 1'b1;
               h_wd     = pick;
               l_we     = 1'b1;
               l_wa     = pick[IW-1:0];
               pos_in   = pick_pos[IW-1:0];
               state_in = ST_DN_RD;
            end else begin
               h_we     = 1'b1;
               l_we     = 1'b1;
               state_in = st_done;
            end
         end

         ST_SCAN_RD: begin
            h_ra = idx_ff[IW-1:0];
            if (idx_ff >= count_ff) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_SCAN_CMP;
            end
         end

         ST_SCAN_CMP: begin
            // hold addresses so the take step sees the same entries
            h_ra = idx_ff[IW-1:0];
            if (qa_hdl == hdl_ff) begin
               slot_in  = idx_ff[IW-1:0];
               state_in = ST_TAKE;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = ST_SCAN_RD;
            end
         end

         ST_FIN: begin
            h_ra     = next_done_dummy;
            state_in = ST_RSP;
         end

         ST_RSP: begin
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         free_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         free_ff  <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      time_ff   <= time_in;
      hdl_ff    <= hdl_in;
      ctx_ff    <= ctx_in;
      sup_ff    <= sup_in;
      pos_ff    <= pos_in;
      slot_ff   <= slot_in;
      idx_ff    <= idx_in;
      mv_ff     <= mv_in;
      first_ff  <= first_in;
      status_ff <= status_in;
      tid_ff    <= tid_in;
      otime_ff  <= otime_in;
      ohdl_ff   <= ohdl_in;
      ccnt_ff   <= ccnt_in;
      notify_ff <= notify_in;
   end

   // result: heap slot 0 was read during the finish step
   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = (state_ff == ST_RSP);
   assign rsp_status        = status_ff;
   assign rsp_tmr_id        = tid_ff;
   assign rsp_out_time      = otime_ff;
   assign rsp_out_handler   = ohdl_ff;
   assign rsp_out_context   = (status_ff == STS_OK &&
                               (act_ff == ACT_CANCEL_ID || act_ff == ACT_REMOVE)) ? c_q : '0;
   assign rsp_cancel_count  = ccnt_ff;
   assign rsp_notify_cancel = notify_ff;
   assign rsp_occupancy     = count_ff;
   assign rsp_head_time     = (count_ff != '0) ? qa_time : '0;

   // occupancy never exceeds the heap size
   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(CAPACITY))
      else $error("heap occupancy above capacity");

   // free list is exhausted exactly when the heap is full
   assert property (@(posedge clock) disable iff (reset)
      (free_ff >= CW'(CAPACITY)) == (count_ff == CW'(CAPACITY)))
      else $error("free list and occupancy disagree");

   // a result strobe lasts one cycle and returns the block to idle
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe longer than one cycle");

   // an accepted item always produces busy on the next cycle
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted item did not start work");

endmodule

FILE: rtl/thq_heap_mem.sv
// Heap array: one entry per slot, two registered read ports, one write port.
module thq_heap_mem #(
   parameter int CAPACITY   = thq_pkg::DEF_CAPACITY,
   parameter int ENTRY_BITS = thq_pkg::DEF_TIME_BITS + thq_pkg::DEF_HANDLER_BITS +
                              $clog2(thq_pkg::DEF_CAPACITY),
   localparam int IW        = $clog2(CAPACITY)
) (
   input  logic                  clock,
   input  logic [IW-1:0]         rd_addr_a,
   input  logic [IW-1:0]         rd_addr_b,
   output logic [ENTRY_BITS-1:0] rd_data_a,
   output logic [ENTRY_BITS-1:0] rd_data_b,
   input  logic                  wr_en,
   input  logic [IW-1:0]         wr_addr,
   input  logic [ENTRY_BITS-1:0] wr_data
);
   import thq_pkg::*;

   logic [ENTRY_BITS-1:0] mem [CAPACITY];
   logic [ENTRY_BITS-1:0] rd_a_ff;
   logic [ENTRY_BITS-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: rtl/thq_id_table.sv
// Per-id storage: link (heap slot or next free id), context word, in-use flags.
module thq_id_table #(
   parameter int CAPACITY     = thq_pkg::DEF_CAPACITY,
   parameter int CONTEXT_BITS = thq_pkg::DEF_CONTEXT_BITS,
   localparam int IW          = $clog2(CAPACITY),
   localparam int CW          = $clog2(CAPACITY + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [IW-1:0]           link_rd_addr,
   output logic [CW-1:0]           link_rd_data,
   input  logic                    link_wr_en,
   input  logic [IW-1:0]           link_wr_addr,
   input  logic [CW-1:0]           link_wr_data,
   input  logic                    ctx_rd_en,
   input  logic [IW-1:0]           ctx_rd_addr,
   output logic [CONTEXT_BITS-1:0] ctx_rd_data,
   input  logic                    ctx_wr_en,
   input  logic [IW-1:0]           ctx_wr_addr,
   input  logic [CONTEXT_BITS-1:0] ctx_wr_data,
   input  logic                    use_wr_en,
   input  logic [IW-1:0]           use_wr_addr,
   input  logic                    use_wr_data,
   input  logic [IW-1:0]           use_rd_addr,
   output logic                    use_rd_data
);
   import thq_pkg::*;

   logic [CW-1:0]           link_mem [CAPACITY];
   logic [CONTEXT_BITS-1:0] ctx_mem  [CAPACITY];
   logic [CAPACITY-1:0]     link_vld_ff;
   logic [CAPACITY-1:0]     in_use_ff;
   logic [CW-1:0]           link_q_ff;
   logic                    link_vld_q_ff;
   logic [IW-1:0]           link_addr_q_ff;
   logic [CONTEXT_BITS-1:0] ctx_q_ff;
   logic                    use_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_vld_ff <= '0;
         in_use_ff   <= '0;
      end else begin
         if (link_wr_en) begin
            link_vld_ff[link_wr_addr] <= 1'b1;
         end
         if (use_wr_en) begin
            in_use_ff[use_wr_addr] <= use_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (link_wr_en) begin
         link_mem[link_wr_addr] <= link_wr_data;
      end
      if (ctx_wr_en) begin
         ctx_mem[ctx_wr_addr] <= ctx_wr_data;
      end
      link_q_ff      <= link_mem[link_rd_addr];
      link_vld_q_ff  <= link_vld_ff[link_rd_addr];
      link_addr_q_ff <= link_rd_addr;
      use_q_ff       <= in_use_ff[use_rd_addr];
      if (ctx_rd_en) begin
         ctx_q_ff <= ctx_mem[ctx_rd_addr];
      end
   end

   // unwritten link entries read as the initial free chain (id + 1)
   assign link_rd_data = link_vld_q_ff ? link_q_ff : (CW'(link_addr_q_ff) + CW'(1));
   assign ctx_rd_data  = ctx_q_ff;
   assign use_rd_data  = use_q_ff;

endmodule
